### rtl/rgbalf_pkg.sv
// Shared types, widths and stage numbering for the RGBA blend-and-fade pipeline.
package rgbalf_pkg;

    localparam int CHAN_W     = 8;
    localparam int WEIGHT_W   = 17;
    localparam int TIME_W     = 32;
    localparam int DUR_W      = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Datapath widths. A blend is Q8.16 and stays below 2^24.
    localparam int PROD_W    = WEIGHT_W + CHAN_W;
    localparam int BLEND_W   = 24;
    localparam int NUM_W     = 33;
    localparam int NUM_SPLIT = 16;
    localparam int PP_HI_W   = BLEND_W + NUM_W - NUM_SPLIT;
    localparam int PP_LO_W   = BLEND_W + NUM_SPLIT;
    localparam int PSUM_W    = BLEND_W + NUM_W - NUM_SPLIT;
    localparam int REM_W     = DUR_W + CHAN_W;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;
    localparam logic [CHAN_W-1:0]   CHAN_MAX   = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] REG_FADE_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_START    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_DURATION = 2'd2;

    // Pipeline stage numbers.
    localparam int NUM_STAGES   = 14;
    localparam int ST_BLEND     = 1;
    localparam int ST_MUL       = 2;
    localparam int ST_SUM       = 3;
    localparam int ST_SAT       = 4;
    localparam int ST_DIV_FIRST = 5;
    localparam int ST_OUT       = NUM_STAGES - 1;

    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_ZERO,
        KIND_DIV
    } kind_t;

    typedef struct packed {
        logic [CHAN_W-1:0]          first_red;
        logic [CHAN_W-1:0]          first_green;
        logic [CHAN_W-1:0]          first_blue;
        logic [CHAN_W-1:0]          first_alpha;
        logic [CHAN_W-1:0]          second_red;
        logic [CHAN_W-1:0]          second_green;
        logic [CHAN_W-1:0]          second_blue;
        logic [CHAN_W-1:0]          second_alpha;
        logic [WEIGHT_W-1:0]        blend_weight;
        logic signed [TIME_W-1:0]   elapsed_time;
    } pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_alpha;
    } result_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
        logic [WEIGHT_W-1:0]   weight;
        logic [NUM_W-1:0]      num;
        logic [DUR_W-1:0]      dur;
        kind_t                 kind;
    } chan_ctrl_t;

endpackage

### rtl/rgba_lerp_with_fade_top.sv
// Top level of the RGBA blend-and-fade pipeline: configuration, control and four channels.
//
// Each input beat carries two RGBA colors, a Q1.16 weight and a Q16.16 time; each
// result beat carries the four blended channels, optionally scaled by a linear fade
// (a step fade when the duration is zero) and saturated at 255. The block takes one
// beat per clock while the input is not stalled. The pipeline holds the product and blend
// stages, the two-stage fade multiply, a saturation check and an eight-step restoring
// divider (one quotient bit per stage), ahead of the output register. Every stage is a
// register with its own valid bit, so a stalled output only stalls the input once all
// stages hold a beat. Configuration writes are taken in any cycle (ready is always high)
// and must only be issued while no beat is in flight.
module rgba_lerp_with_fade_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pixel_valid,
    output logic                              pixel_stall,
    input  rgbalf_pkg::pixel_t                pixel,
    output logic                              result_valid,
    input  logic                              result_stall,
    output rgbalf_pkg::result_t               result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rgbalf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rgbalf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rgbalf_pkg::*;

    logic                     fade_enable_reg;
    logic signed [TIME_W-1:0] fade_start_reg;
    logic [DUR_W-1:0]         fade_duration_reg;

    logic [NUM_STAGES-1:0]    valid_reg;
    logic [NUM_STAGES-1:0]    en;
    kind_t                    kind_reg [0:ST_OUT-1];
    logic [NUM_W-1:0]         num_reg  [0:ST_BLEND];

    logic [WEIGHT_W-1:0]      weight_sat;
    logic signed [NUM_W:0]    num_full;
    logic                     before_start;
    kind_t                    kind_next;
    chan_ctrl_t               ctrl;

    logic [CHAN_W-1:0]        red_value;
    logic [CHAN_W-1:0]        green_value;
    logic [CHAN_W-1:0]        blue_value;
    logic [CHAN_W-1:0]        alpha_value;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_enable_reg   <= 1'b0;
            fade_start_reg    <= '0;
            fade_duration_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FADE_ENABLE:   fade_enable_reg   <= cfg_data[0];
                REG_FADE_START:    fade_start_reg    <= $signed(cfg_data);
                REG_FADE_DURATION: fade_duration_reg <= cfg_data[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb
    begin
        en[ST_OUT] = !valid_reg[ST_OUT] || !result_stall;
        for (int s = ST_OUT - 1; s >= 0; s--)
        begin
            en[s] = !valid_reg[s] || en[s+1];
        end
    end

    assign pixel_stall  = !en[0];
    assign result_valid = valid_reg[ST_OUT];

    assign weight_sat = (pixel.blend_weight > WEIGHT_ONE) ? WEIGHT_ONE : pixel.blend_weight;

    // Fade numerator: duration - (elapsed - start), at full signed precision.
    assign num_full = $signed({3'b000, fade_duration_reg})
                    - $signed({{2{pixel.elapsed_time[TIME_W-1]}}, pixel.elapsed_time})
                    + $signed({{2{fade_start_reg[TIME_W-1]}}, fade_start_reg});

    assign before_start = $signed(pixel.elapsed_time) < fade_start_reg;

    always_comb
    begin
        if (!fade_enable_reg)
        begin
            kind_next = KIND_PASS;
        end
        else if (fade_duration_reg == '0)
        begin
            kind_next = before_start ? KIND_PASS : KIND_ZERO;
        end
        else if (num_full[NUM_W] || (num_full == '0))
        begin
            kind_next = KIND_ZERO;
        end
        else
        begin
            kind_next = KIND_DIV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= pixel_valid;
            end
            for (int s = 1; s < NUM_STAGES; s++)
            begin
                if (en[s])
                begin
                    valid_reg[s] <= valid_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            kind_reg[0] <= kind_next;
            num_reg[0]  <= num_full[NUM_W-1:0];
        end
        if (en[ST_BLEND])
        begin
            num_reg[ST_BLEND] <= num_reg[0];
        end
        for (int s = 1; s < ST_OUT; s++)
        begin
            if (en[s])
            begin
                kind_reg[s] <= kind_reg[s-1];
            end
        end
    end

    assign ctrl = '{
        en:     en,
        weight: weight_sat,
        num:    num_reg[ST_BLEND],
        dur:    fade_duration_reg,
        kind:   kind_reg[ST_OUT-1]
    };

    rgbalf_chan u_chan_red (
        .clk    (clk),
        .first  (pixel.first_red),
        .second (pixel.second_red),
        .ctrl   (ctrl),
        .value  (red_value)
    );

    rgbalf_chan u_chan_green (
        .clk    (clk),
        .first  (pixel.first_green),
        .second (pixel.second_green),
        .ctrl   (ctrl),
        .value  (green_value)
    );

    rgbalf_chan u_chan_blue (
        .clk    (clk),
        .first  (pixel.first_blue),
        .second (pixel.second_blue),
        .ctrl   (ctrl),
        .value  (blue_value)
    );

    rgbalf_chan u_chan_alpha (
        .clk    (clk),
        .first  (pixel.first_alpha),
        .second (pixel.second_alpha),
        .ctrl   (ctrl),
        .value  (alpha_value)
    );

    assign result = '{
        out_red:   red_value,
        out_green: green_value,
        out_blue:  blue_value,
        out_alpha: alpha_value
    };

`ifndef SYNTHESIS
    // The input may only stall once every stage holds a beat and the output is blocked.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> ((&valid_reg) && result_stall))
        else $error("input stalled while the pipeline has an empty stage");

    // A beat in the last divider stage moves into an empty output register.
    a_output_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[ST_OUT-1] && !valid_reg[ST_OUT]) |=> valid_reg[ST_OUT])
        else $error("beat did not advance into the empty output register");

    // A beat sent to the divider always carries a nonzero fade numerator.
    a_div_numerator: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[ST_BLEND] && (kind_reg[ST_BLEND] == KIND_DIV)) |->
        (num_reg[ST_BLEND] != '0))
        else $error("divider beat with zero fade numerator");
`endif

endmodule

### rtl/rgbalf_chan.sv
// Datapath of one color channel: blend, scale by the fade numerator, divide, saturate.
module rgbalf_chan (
    input  logic                           clk,
    input  logic [rgbalf_pkg::CHAN_W-1:0]  first,
    input  logic [rgbalf_pkg::CHAN_W-1:0]  second,
    input  rgbalf_pkg::chan_ctrl_t         ctrl,
    output logic [rgbalf_pkg::CHAN_W-1:0]  value
);
    import rgbalf_pkg::*;

    logic [WEIGHT_W-1:0] inv_weight;
    logic [PROD_W-1:0]   prod_first;
    logic [PROD_W-1:0]   prod_second;
    logic [PP_HI_W-1:0]  pp_hi_next;
    logic [PP_LO_W-1:0]  pp_lo_next;
    logic [PSUM_W-1:0]   psum_next;
    logic [PSUM_W-1:0]   sat_limit;

    logic [BLEND_W-1:0]  pfirst_reg;
    logic [BLEND_W-1:0]  psecond_reg;
    logic [BLEND_W-1:0]  blend_reg;
    logic [PP_HI_W-1:0]  pp_hi_reg;
    logic [PP_LO_W-1:0]  pp_lo_reg;
    logic [PSUM_W-1:0]   psum_reg;
    logic [REM_W-1:0]    rem_reg  [ST_SAT:ST_OUT-1];
    logic [CHAN_W-1:0]   quo_reg  [ST_SAT:ST_OUT-1];
    logic                sat_reg  [ST_SAT:ST_OUT-1];
    logic [CHAN_W-1:0]   pass_reg [ST_MUL:ST_OUT-1];
    logic [CHAN_W-1:0]   value_reg;

    logic [REM_W-1:0]    trial [ST_DIV_FIRST:ST_OUT-1];
    logic                fits  [ST_DIV_FIRST:ST_OUT-1];

    assign inv_weight  = WEIGHT_ONE - ctrl.weight;
    assign prod_first  = {{(PROD_W-WEIGHT_W){1'b0}}, inv_weight}
                       * {{(PROD_W-CHAN_W){1'b0}}, first};
    assign prod_second = {{(PROD_W-WEIGHT_W){1'b0}}, ctrl.weight}
                       * {{(PROD_W-CHAN_W){1'b0}}, second};

    // The numerator is split in two halves so each multiplier stays narrow.
    assign pp_hi_next = {{(PP_HI_W-BLEND_W){1'b0}}, blend_reg}
                      * {{(PP_HI_W-(NUM_W-NUM_SPLIT)){1'b0}}, ctrl.num[NUM_W-1:NUM_SPLIT]};
    assign pp_lo_next = {{(PP_LO_W-BLEND_W){1'b0}}, blend_reg}
                      * {{(PP_LO_W-NUM_SPLIT){1'b0}}, ctrl.num[NUM_SPLIT-1:0]};

    // Dropping the low 16 bits of the product folds the Q16 scale of the divisor in.
    assign psum_next = pp_hi_reg
                     + {{(PSUM_W-(PP_LO_W-NUM_SPLIT)){1'b0}}, pp_lo_reg[PP_LO_W-1:NUM_SPLIT]};

    assign sat_limit = {{(PSUM_W-DUR_W-CHAN_W){1'b0}}, ctrl.dur, {CHAN_W{1'b0}}};

    // One restoring division step per stage, most significant quotient bit first.
    always_comb
    begin
        for (int s = ST_DIV_FIRST; s < ST_OUT; s++)
        begin
            trial[s] = {{(REM_W-DUR_W){1'b0}}, ctrl.dur} << (ST_OUT - 1 - s);
            fits[s]  = rem_reg[s-1] >= trial[s];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[0])
        begin
            pfirst_reg  <= prod_first[BLEND_W-1:0];
            psecond_reg <= prod_second[BLEND_W-1:0];
        end
        if (ctrl.en[ST_BLEND])
        begin
            blend_reg <= pfirst_reg + psecond_reg;
        end
        if (ctrl.en[ST_MUL])
        begin
            pp_hi_reg        <= pp_hi_next;
            pp_lo_reg        <= pp_lo_next;
            pass_reg[ST_MUL] <= blend_reg[BLEND_W-1 -: CHAN_W];
        end
        if (ctrl.en[ST_SUM])
        begin
            psum_reg         <= psum_next;
            pass_reg[ST_SUM] <= pass_reg[ST_MUL];
        end
        // A quotient of 256 or more saturates, so only eight bits are developed.
        if (ctrl.en[ST_SAT])
        begin
            rem_reg[ST_SAT]  <= psum_reg[REM_W-1:0];
            quo_reg[ST_SAT]  <= '0;
            sat_reg[ST_SAT]  <= psum_reg >= sat_limit;
            pass_reg[ST_SAT] <= pass_reg[ST_SUM];
        end
        for (int s = ST_DIV_FIRST; s < ST_OUT; s++)
        begin
            if (ctrl.en[s])
            begin
                rem_reg[s]  <= fits[s] ? rem_reg[s-1] - trial[s] : rem_reg[s-1];
                quo_reg[s]  <= {quo_reg[s-1][CHAN_W-2:0], fits[s]};
                sat_reg[s]  <= sat_reg[s-1];
                pass_reg[s] <= pass_reg[s-1];
            end
        end
        if (ctrl.en[ST_OUT])
        begin
            case (ctrl.kind)
                KIND_PASS: value_reg <= pass_reg[ST_OUT-1];
                KIND_DIV:  value_reg <= sat_reg[ST_OUT-1] ? CHAN_MAX : quo_reg[ST_OUT-1];
                default:   value_reg <= '0;
            endcase
        end
    end

    assign value = value_reg;

endmodule

### test/testbench.sv
// Self-checking testbench for the RGBA blend-and-fade pipeline with a scoreboard class.
module testbench;
    import rgbalf_pkg::*;

    typedef longint unsigned u64_t;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int IDLE_PCT      = 29;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_PIXELS  = 53;
    localparam int CALM_PHASE    = 2;
    localparam int SQUEEZE_PHASE = 5;
    localparam int HOLD_LEN      = 60;
    localparam int QUIET_LIMIT   = 1000;

    // Index past the last register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    class fade_ledger;
        result_t                  due_q[$];
        bit                       fade_on    = 1'b0;
        logic signed [TIME_W-1:0] fade_from  = '0;
        logic [DUR_W-1:0]         fade_len   = '0;
        int                       faults     = 0;
        int                       pixels_in  = 0;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_FADE_ENABLE:   fade_on = data[0];
                REG_FADE_START:    fade_from = data;
                REG_FADE_DURATION: fade_len = data[DUR_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [CHAN_W-1:0] fade_chan(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b,
                                              logic [WEIGHT_W-1:0] w,
                                              logic signed [TIME_W-1:0] t);
            u64_t   mix;
            u64_t   quo;
            longint span;
            mix = u64_t'(w) * u64_t'(b) + u64_t'(WEIGHT_ONE - w) * u64_t'(a);
            quo = mix >> 16;
            if (fade_on)
            begin
                if (fade_len == 0)
                begin
                    // Step fade: full color before the start time, black from it on.
                    if (!(t < fade_from))
                        quo = 0;
                end
                else
                begin
                    span = longint'(fade_len) - (longint'(t) - longint'(fade_from));
                    if (span <= 0)
                        quo = 0;
                    else
                        quo = (mix * u64_t'(span)) / (u64_t'(fade_len) << 16);
                end
            end
            return (quo > CHAN_MAX) ? CHAN_MAX : quo[CHAN_W-1:0];
        endfunction

        function void note_pixel(pixel_t p);
            result_t             r;
            logic [WEIGHT_W-1:0] w;
            w = (p.blend_weight > WEIGHT_ONE) ? WEIGHT_ONE : p.blend_weight;
            r.out_red   = fade_chan(p.first_red,   p.second_red,   w, p.elapsed_time);
            r.out_green = fade_chan(p.first_green, p.second_green, w, p.elapsed_time);
            r.out_blue  = fade_chan(p.first_blue,  p.second_blue,  w, p.elapsed_time);
            r.out_alpha = fade_chan(p.first_alpha, p.second_alpha, w, p.elapsed_time);
            due_q.push_back(r);
            pixels_in++;
        endfunction

        function void check_result(result_t got);
            result_t want;
            string   names[4];
            int      c;
            names = '{"out_red", "out_green", "out_blue", "out_alpha"};
            if (due_q.size() == 0)
            begin
                faults++;
                $error("result beat %h arrived with no pixel outstanding", got);
                return;
            end
            want = due_q.pop_front();
            for (c = 0; c < 4; c++)
            begin
                if (got[31-8*c -: 8] !== want[31-8*c -: 8])
                begin
                    faults++;
                    $error("%s: expected %0d, got %0d", names[c],
                           want[31-8*c -: 8], got[31-8*c -: 8]);
                end
            end
        endfunction

        function int outstanding();
            return due_q.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  pixel_valid = 1'b0;
    logic                  pixel_stall;
    pixel_t                pixel = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    fade_ledger ledger = new();
    bit         gaps_on = 1'b1;
    bit         stalls_on = 1'b1;
    int         squeeze_req = 0;
    int         settings_run = 0;

    rgba_lerp_with_fade_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic pixel_t pack_pixel(input logic [31:0] c1, input logic [31:0] c2,
                                          input logic [WEIGHT_W-1:0] w,
                                          input logic [TIME_W-1:0] t);
        return {c1, c2, w, t};
    endfunction

    task automatic send_pixel(input pixel_t p);
        while (gaps_on && ($urandom_range(0, 99) < IDLE_PCT))
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel <= p;
        pixel_valid <= 1'b1;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        ledger.note_pixel(p);
    endtask

    // Registers may only change with nothing in flight, so drain first.
    task automatic program_fade(input logic [31:0] en_word, input logic [31:0] from_word,
                                input logic [31:0] len_word, input bit poke_spare);
        logic [CFG_IDX_W-1:0]  idx[4];
        logic [CFG_DATA_W-1:0] word[4];
        int                    n;
        int                    k;
        pixel_valid <= 1'b0;
        while (ledger.outstanding() != 0)
            @(posedge clk);
        idx[0] = REG_FADE_ENABLE;
        word[0] = en_word;
        idx[1] = REG_FADE_START;
        word[1] = from_word;
        idx[2] = REG_FADE_DURATION;
        word[2] = len_word;
        idx[3] = REG_SPARE;
        word[3] = $urandom;
        n = poke_spare ? 4 : 3;
        for (k = 0; k < n; k++)
        begin
            cfg_index <= idx[k];
            cfg_data <= word[k];
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            ledger.set_reg(idx[k], word[k]);
        end
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    // Result side: random stalls, plus one long hold when the stimulus asks for it.
    initial
    begin : receiver
        int hold_left;
        int squeeze_done;
        hold_left = 0;
        squeeze_done = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
                ledger.check_result(result);
            if (hold_left == 0 && squeeze_req != squeeze_done)
            begin
                hold_left = HOLD_LEN;
                squeeze_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= stalls_on && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("rgba_lerp_with_fade_top: mismatch");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [31:0]         from_ts;
        logic [31:0]         en_word;
        logic [31:0]         from_word;
        logic [31:0]         len_word;
        logic [31:0]         c1;
        logic [31:0]         c2;
        logic [WEIGHT_W-1:0] w;
        longint              t;
        int                  ph;
        int                  k;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fade off after reset: weight extremes and weights above one.
        send_pixel(pack_pixel(32'h0, 32'h0, 17'd0, 32'h0));
        send_pixel(pack_pixel(32'hFFFF_FFFF, 32'h0, 17'd0, 32'h0));
        send_pixel(pack_pixel(32'h0, 32'hFFFF_FFFF, WEIGHT_ONE, 32'h0));
        send_pixel(pack_pixel(32'h1122_3344, 32'hFFEE_DDCC, 17'h1FFFF, 32'h0));
        send_pixel(pack_pixel(32'h00FF_00FF, 32'hFF00_FF00, 17'd32768, 32'h8000_0000));
        send_pixel(pack_pixel($urandom, $urandom, 17'd1, 32'h7FFF_FFFF));
        send_pixel(pack_pixel(32'hFFFF_FFFF, 32'h0, 17'd65537, 32'h0));

        // Step fade at time zero, with a write to the unused index.
        program_fade(32'h1, 32'h0, 32'h0, 1'b1);
        send_pixel(pack_pixel(32'hFFFF_FFFF, 32'h0, 17'd0, 32'hFFFF_FFFF));
        send_pixel(pack_pixel(32'hFFFF_FFFF, 32'h0, 17'd0, 32'h0));
        send_pixel(pack_pixel(32'hFFFF_FFFF, 32'h0, 17'd0, 32'h1));
        send_pixel(pack_pixel(32'hFFFF_FFFF, 32'h0, 17'd0, 32'h8000_0000));
        send_pixel(pack_pixel(32'hFFFF_FFFF, 32'h0, 17'd0, 32'h7FFF_FFFF));

        // Linear fade from 100.0 over 10.0; before the start the factor exceeds one.
        from_ts = 32'd100 << 16;
        program_fade(32'h1, from_ts, 32'd10 << 16, 1'b0);
        send_pixel(pack_pixel(32'h4020_1008, 32'h0, 17'd0, 32'h0));
        send_pixel(pack_pixel(32'h4020_1008, 32'hFFFF_FFFF, 17'd40000, from_ts));
        send_pixel(pack_pixel(32'hFFFF_FFFF, 32'h8080_8080, 17'd20000, from_ts + (5 << 16)));
        send_pixel(pack_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd0, from_ts + (10 << 16) - 1));
        send_pixel(pack_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd0, from_ts + (10 << 16)));
        send_pixel(pack_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd0, from_ts + (10 << 16) + 1));

        // Earliest start and longest duration; bit 31 of the duration word is dropped.
        program_fade(32'h1, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        send_pixel(pack_pixel(32'hFFFF_FFFF, 32'h0, 17'd0, 32'h7FFF_FFFF));
        send_pixel(pack_pixel(32'hFFFF_FFFF, 32'h0, 17'd0, 32'h8000_0000));
        send_pixel(pack_pixel(32'hFFFF_FFFF, 32'h0, 17'd0, 32'hFFFF_FFFF));
        send_pixel(pack_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd0, 32'hFFFF_FFFE));

        // Only bit 0 of the enable word counts.
        program_fade(32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'h0, 1'b0);
        send_pixel(pack_pixel(32'h1234_5678, 32'h9ABC_DEF0, 17'd30000, 32'h8000_0000));

        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            en_word = $urandom;
            en_word[0] = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 4))
                0: from_word = 32'h0;
                1: from_word = 32'h8000_0000;
                2: from_word = 32'h7FFF_FFFF;
                3: from_word = $urandom;
                default: from_word = 32'($urandom_range(0, 2000 << 16)) - (1000 << 16);
            endcase
            case ($urandom_range(0, 4))
                0: len_word = 32'h0;
                1: len_word = 32'h7FFF_FFFF;
                2: len_word = $urandom_range(1, 16);
                3: len_word = $urandom_range(1, 64 << 16);
                default: len_word = $urandom;
            endcase
            len_word[31] = 1'($urandom_range(0, 1));
            program_fade(en_word, from_word, len_word, ph == 0);

            gaps_on = (ph != CALM_PHASE) && (ph != SQUEEZE_PHASE);
            stalls_on = (ph != CALM_PHASE);
            if (ph == SQUEEZE_PHASE)
                squeeze_req++;

            for (k = 0; k < PHASE_PIXELS; k++)
            begin
                c1 = $urandom;
                c2 = $urandom;
                if ($urandom_range(0, 9) == 0)
                    c1 = 32'hFFFF_FFFF;
                if ($urandom_range(0, 9) == 0)
                    c2 = 32'hFFFF_FFFF;
                case ($urandom_range(0, 9))
                    0: w = '0;
                    1: w = WEIGHT_ONE;
                    2: w = WEIGHT_W'($urandom_range(65537, 131071));
                    default: w = WEIGHT_W'($urandom_range(0, 65536));
                endcase
                // Most times fall around the fade window so that the factor varies.
                case ($urandom_range(0, 9))
                    0, 1, 2: t = longint'($urandom);
                    3: t = longint'(ledger.fade_from) + longint'(ledger.fade_len);
                    default:
                    begin
                        if (ledger.fade_len == 0)
                            t = longint'(ledger.fade_from) + $urandom_range(0, 8) - 4;
                        else
                            t = longint'(ledger.fade_from)
                                + longint'($urandom_range(0, ledger.fade_len
                                                          + ledger.fade_len / 4))
                                - longint'(ledger.fade_len / 8);
                    end
                endcase
                send_pixel(pack_pixel(c1, c2, w, t[31:0]));
            end
        end
        pixel_valid <= 1'b0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;

        while (ledger.outstanding() != 0)
            @(posedge clk);
        repeat (2 * NUM_STAGES) @(posedge clk);

        $display("Covered %0d pixel beats over %0d fade settings, including step fades,",
                 ledger.pixels_in, settings_run);
        $display("weights above one, factors above one and a full-pipeline output hold.");
        if (ledger.faults == 0 && ledger.outstanding() == 0)
            $display("rgba_lerp_with_fade_top: match");
        else
            $display("rgba_lerp_with_fade_top: mismatch");
        $finish;
    end
endmodule

### sim.f
rtl/rgbalf_pkg.sv
rtl/rgbalf_chan.sv
rtl/rgba_lerp_with_fade_top.sv
test/testbench.sv
